@@ hdl/dpp_pkg.sv @@
// Shared constants, types and sequencer states of the delta pattern prefetcher.
package dpp_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int DELTA_SLOTS   = 16;
  localparam int DATA_W        = 32;

  localparam int ENTRY_W    = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W     = $clog2(DELTA_SLOTS);
  localparam int CNT_W      = $clog2(DELTA_SLOTS + 1);
  localparam int ROW_W      = $clog2(TABLE_ENTRIES + 1);
  // One spare row holds the ring shared by all entries that still carry pc zero
  localparam int RING_DEPTH = (TABLE_ENTRIES + 1) * DELTA_SLOTS;
  localparam int RING_AW    = ROW_W + SLOT_W;

  localparam logic [ROW_W-1:0] ZERO_ROW = ROW_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic [DATA_W-1:0] pc;
    logic [DATA_W-1:0] last_addr;
    logic [SLOT_W-1:0] pos;
    logic [CNT_W-1:0]  cnt;
  } meta_t;

  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
    logic [DATA_W-1:0]  data;
  } ring_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_UPDATE,
    ST_PAT_RD,
    ST_PAT_CMP,
    ST_SUM_RD,
    ST_SUM_ADD,
    ST_FLUSH
  } state_t;

endpackage

@@ hdl/dpp_ring_ram.sv @@
// Delta ring store: one write port, two registered read ports.
module dpp_ring_ram (
  input  logic                           clk,
  input  dpp_pkg::ring_wr_t              wr,
  input  logic [dpp_pkg::RING_AW-1:0]    raddr_a,
  input  logic [dpp_pkg::RING_AW-1:0]    raddr_b,
  output logic [dpp_pkg::DATA_W-1:0]     rdata_a,
  output logic [dpp_pkg::DATA_W-1:0]     rdata_b
);

  logic [dpp_pkg::DATA_W-1:0] mem [dpp_pkg::RING_DEPTH];

  // Write one delta, read two
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hdl/delta_pattern_prefetcher_core.sv @@
// Top level of the delta pattern prefetcher: table scan, pattern search, prefetch output.
//
// Usage:
//   s_axis carries one access item: tdata[31:0] pc, tdata[63:32] address.
//   m_axis returns zero to fifteen prefetch items per access, tdata the
//   address and tlast marking the final prefetch of that access.
//   cfg writes the prefetch address limit; it is always ready.
// Sequence:
//   An access takes its pc lookup, a scan of the entry table at one entry
//   per cycle (stopping at a hit; a pc of zero skips the scan), then a read
//   and a compare state per delta compare of the pattern search (lengths p
//   up to cnt/2), then a read and an add state per running-sum step.
//   The single metadata read port paces the scan and the two-port delta ring
//   memory the compare and sum steps. s_axis is ready only between accesses.
// Reset clears the sequencer, the replacement pointer and marks every entry
// as a reset entry; no memory clearing pass is needed. When m_axis stalls,
// the output register holds and the sequencer waits before each further
// prefetch; the next access may be taken while the last result still waits.
module delta_pattern_prefetcher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] access_pc, [63:32] access_addr
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] prefetch_addr
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data        // [31:0] max_address
);

  localparam int DW = dpp_pkg::DATA_W;
  localparam int EW = dpp_pkg::ENTRY_W;
  localparam int SW = dpp_pkg::SLOT_W;
  localparam int CW = dpp_pkg::CNT_W;
  localparam int RW = dpp_pkg::ROW_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(dpp_pkg::DELTA_SLOTS);
  localparam logic [dpp_pkg::TABLE_ENTRIES-1:0] ZGRP_ONE = dpp_pkg::TABLE_ENTRIES'(1);

  dpp_pkg::state_t state, state_next;

  logic [DW-1:0] pc_r, addr_r, max_addr;
  logic [dpp_pkg::TABLE_ENTRIES-1:0] zgrp;
  logic [DW-1:0] zlast;
  logic [SW-1:0] zpos;
  logic [CW-1:0] zcnt;
  logic [EW-1:0] replace_pos;

  dpp_pkg::meta_t meta_mem [dpp_pkg::TABLE_ENTRIES];
  dpp_pkg::meta_t meta_q;
  logic [EW:0]    scan_idx;
  logic           rd_v;
  logic [EW-1:0]  rd_idx;

  logic [RW-1:0] row;
  logic [DW-1:0] wlast;
  logic [SW-1:0] wptr;
  logic [CW-1:0] wcnt;
  logic [CW-1:0] pat_p;
  logic [SW-1:0] pat_i, pat_j, last_idx, start;
  logic          matched;
  logic [DW-1:0] prev, pend;
  logic          have_pend;

  dpp_pkg::ring_wr_t ring_wr;
  logic [dpp_pkg::RING_AW-1:0] raddr_a, raddr_b;
  logic [DW-1:0] rdata_a, rdata_b;

  logic          hit_now, scan_end, slot_free, push, push_last;
  logic [DW-1:0] push_data, pf;
  logic          qual, stall, eq, end_p;
  logic [SW-1:0] idx_a, idx_b;
  logic [SW-1:0] new_pos;
  logic [CW-1:0] new_cnt;
  logic [CW:0]   i_sum;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == dpp_pkg::ST_IDLE);
  assign slot_free     = !m_axis_tvalid || m_axis_tready;

  // Ring addresses for the pattern compare and the running sum
  assign idx_a   = wptr - pat_p[SW-1:0] + pat_j;
  assign idx_b   = wptr - wcnt[SW-1:0] + pat_i;
  assign raddr_a = {row, ((state == dpp_pkg::ST_SUM_RD || state == dpp_pkg::ST_SUM_ADD)
                          ? start : idx_a)};
  assign raddr_b = {row, idx_b};

  assign new_pos = wptr + SW'(1);
  assign new_cnt = (wcnt == FULL_CNT) ? wcnt : wcnt + CW'(1);

  assign hit_now  = rd_v && !zgrp[rd_idx] && (meta_q.pc == pc_r);
  assign scan_end = rd_v && (rd_idx == EW'(dpp_pkg::TABLE_ENTRIES - 1));

  assign eq    = (rdata_a == rdata_b);
  assign i_sum = {2'b00, pat_i} + (CW+1)'(1) + {1'b0, pat_p};
  assign end_p = (i_sum >= {1'b0, wcnt});

  assign pf    = prev + rdata_a;
  assign qual  = (pf != '0) && (pf < max_addr);
  assign stall = qual && have_pend && !slot_free;

  assign ring_wr.en   = (state == dpp_pkg::ST_UPDATE);
  assign ring_wr.addr = {row, wptr};
  assign ring_wr.data = addr_r - wlast;

  dpp_ring_ram u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Sequencer: next state and output pushes
  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_data  = pend;
    push_last  = 1'b0;
    unique case (state)
      dpp_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_next = dpp_pkg::ST_SCAN;
      end
      dpp_pkg::ST_SCAN: begin
        if (pc_r == '0) begin
          state_next = (zgrp != '0) ? dpp_pkg::ST_UPDATE : dpp_pkg::ST_MISS;
        end else if (hit_now) begin
          state_next = dpp_pkg::ST_UPDATE;
        end else if (scan_end) begin
          state_next = dpp_pkg::ST_MISS;
        end
      end
      dpp_pkg::ST_MISS: state_next = dpp_pkg::ST_IDLE;
      dpp_pkg::ST_UPDATE: begin
        state_next = (new_cnt >= CW'(2)) ? dpp_pkg::ST_PAT_RD : dpp_pkg::ST_SUM_RD;
      end
      dpp_pkg::ST_PAT_RD: state_next = dpp_pkg::ST_PAT_CMP;
      dpp_pkg::ST_PAT_CMP: begin
        if (end_p && ((pat_p + CW'(1)) > (wcnt >> 1))) state_next = dpp_pkg::ST_SUM_RD;
        else state_next = dpp_pkg::ST_PAT_RD;
      end
      dpp_pkg::ST_SUM_RD: begin
        state_next = (start == wptr) ? dpp_pkg::ST_FLUSH : dpp_pkg::ST_SUM_ADD;
      end
      dpp_pkg::ST_SUM_ADD: begin
        if (!stall) begin
          state_next = dpp_pkg::ST_SUM_RD;
          push       = qual && have_pend;
        end
      end
      dpp_pkg::ST_FLUSH: begin
        if (!have_pend) begin
          state_next = dpp_pkg::ST_IDLE;
        end else if (slot_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = dpp_pkg::ST_IDLE;
        end
      end
      default: state_next = dpp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dpp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_addr <= '1;
    end else if (cfg_valid) begin
      max_addr <= cfg_data;
    end
  end

  // Metadata memory: read one entry a cycle during the scan
  always_ff @(posedge clk) begin
    meta_q <= meta_mem[scan_idx[EW-1:0]];
    if (state == dpp_pkg::ST_MISS && pc_r != '0) begin
      meta_mem[replace_pos] <= '{pc: pc_r, last_addr: addr_r, pos: '0, cnt: '0};
    end else if (state == dpp_pkg::ST_UPDATE && row != dpp_pkg::ZERO_ROW) begin
      meta_mem[row[EW-1:0]] <= '{pc: pc_r, last_addr: addr_r, pos: new_pos, cnt: new_cnt};
    end
  end

  // Table control: reset-entry group, zero-pc ring metadata, replacement pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      zgrp        <= '1;
      zlast       <= '0;
      zpos        <= '0;
      zcnt        <= '0;
      replace_pos <= '0;
    end else if (state == dpp_pkg::ST_MISS) begin
      if (pc_r == '0) begin
        zgrp  <= ZGRP_ONE << replace_pos;
        zlast <= addr_r;
        zpos  <= '0;
        zcnt  <= '0;
      end else begin
        zgrp[replace_pos] <= 1'b0;
      end
      replace_pos <= (replace_pos == EW'(dpp_pkg::TABLE_ENTRIES - 1))
                     ? '0 : replace_pos + EW'(1);
    end else if (state == dpp_pkg::ST_UPDATE && row == dpp_pkg::ZERO_ROW) begin
      zlast <= addr_r;
      zpos  <= new_pos;
      zcnt  <= new_cnt;
    end
  end

  // Working registers of one access
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      case (state)
        dpp_pkg::ST_IDLE: begin
          pc_r     <= s_axis_tdata[31:0];
          addr_r   <= s_axis_tdata[63:32];
          scan_idx <= '0;
          rd_v     <= 1'b0;
        end
        dpp_pkg::ST_SCAN: begin
          // Issue the next read, compare the one that returned
          if (scan_idx[EW] == 1'b0) begin
            rd_v     <= 1'b1;
            rd_idx   <= scan_idx[EW-1:0];
            scan_idx <= scan_idx + (EW+1)'(1);
          end else begin
            rd_v <= 1'b0;
          end
          if (pc_r == '0) begin
            row   <= dpp_pkg::ZERO_ROW;
            wlast <= zlast;
            wptr  <= zpos;
            wcnt  <= zcnt;
          end else begin
            row   <= {1'b0, rd_idx};
            wlast <= meta_q.last_addr;
            wptr  <= meta_q.pos;
            wcnt  <= meta_q.cnt;
          end
        end
        dpp_pkg::ST_UPDATE: begin
          wptr    <= new_pos;
          wcnt    <= new_cnt;
          start   <= new_pos;
          prev    <= addr_r;
          pat_p   <= CW'(1);
          pat_i   <= '0;
          pat_j   <= '0;
          matched <= 1'b0;
        end
        dpp_pkg::ST_PAT_CMP: begin
          if (end_p) begin
            if (eq) start <= idx_b;
            else if (matched) start <= last_idx;
            pat_p   <= pat_p + CW'(1);
            pat_i   <= '0;
            pat_j   <= '0;
            matched <= 1'b0;
          end else begin
            if (eq) begin
              matched  <= 1'b1;
              last_idx <= idx_b;
            end
            pat_i <= pat_i + SW'(1);
            pat_j <= ((pat_j + SW'(1)) == pat_p[SW-1:0]) ? '0 : pat_j + SW'(1);
          end
        end
        dpp_pkg::ST_SUM_ADD: begin
          if (!stall) begin
            prev  <= pf;
            start <= start + SW'(1);
            if (qual) begin
              pend      <= pf;
              have_pend <= 1'b1;
            end
          end
        end
        dpp_pkg::ST_FLUSH: begin
          if (push) have_pend <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= push_data;
      m_axis_tlast  <= push_last;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_pat_len: assert property (@(posedge clk) disable iff (rst)
    (state == dpp_pkg::ST_PAT_RD || state == dpp_pkg::ST_PAT_CMP)
      |-> (pat_p != '0 && {pat_p, 1'b0} <= {1'b0, wcnt}))
    else $error("pattern length out of range");
  a_pat_idx: assert property (@(posedge clk) disable iff (rst)
    (state == dpp_pkg::ST_PAT_CMP)
      |-> ({1'b0, pat_j} < {1'b0, pat_p[SW-1:0]} ||
           pat_p == CW'(dpp_pkg::DELTA_SLOTS)))
    else $error("pattern phase beyond pattern length");
  a_flushed: assert property (@(posedge clk) disable iff (rst)
    $rose(s_axis_tready) |-> !have_pend)
    else $error("pending prefetch left behind");
`endif

endmodule
